[sv/frustum_plane_extract_and_cull_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the frustum plane extraction and culling block
// Each macro samples on the rising clock edge and is disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef FRUSTUM_PLANE_EXTRACT_AND_CULL_TOP_ASSERT_SVH
`define FRUSTUM_PLANE_EXTRACT_AND_CULL_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define FPE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FPE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/fpe_pkg.sv]
// ---------------------------------------------------------------------------
// fpe_pkg
// Shared types and command codes of the frustum plane extraction block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fpe_pkg;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_POINT = 2'd1;
  localparam logic [1:0] CMD_BOX   = 2'd2;

  localparam int NUM_PLANES = 6;
  localparam int COEF_PER_PLANE = 4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [1:0]         row;
    logic signed [31:0] e0;
    logic signed [31:0] e1;
    logic signed [31:0] e2;
    logic signed [31:0] e3;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [30:0]        rad;
  } item_t;

  typedef struct packed {
    logic in_view;
    logic kind;
  } res_t;

endpackage
`default_nettype wire

[sv/fpe_front.sv]
// ---------------------------------------------------------------------------
// fpe_front
// Accepts items, drops unused commands and queues the rest in two entries.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fpe_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire logic [263:0]   s_tdata,
  input  wire logic [1:0]     s_tuser,
  output logic                q_valid,
  input  wire logic           q_ready,
  output fpe_pkg::item_t      q_item
);

  fpe_pkg::item_t mem [2];
  fpe_pkg::item_t in_item;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  always_comb begin
    in_item.cmd = s_tuser;
    in_item.row = s_tdata[1:0];
    in_item.e0  = s_tdata[33:2];
    in_item.e1  = s_tdata[65:34];
    in_item.e2  = s_tdata[97:66];
    in_item.e3  = s_tdata[129:98];
    in_item.px  = s_tdata[161:130];
    in_item.py  = s_tdata[193:162];
    in_item.pz  = s_tdata[225:194];
    in_item.rad = s_tdata[256:226];
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready &&
                    (s_tuser inside {fpe_pkg::CMD_LOAD, fpe_pkg::CMD_POINT, fpe_pkg::CMD_BOX});
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

[sv/fpe_back.sv]
// ---------------------------------------------------------------------------
// fpe_back
// Plane store, normalisation sequencer and shared multiply-accumulate tests.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "frustum_plane_extract_and_cull_top_assert.svh"
module fpe_back #(
  parameter int CW        = 32,
  parameter int FRAC_BITS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire fpe_pkg::item_t q_item,
  output logic                res_valid,
  input  wire logic           res_ready,
  output fpe_pkg::res_t       res
);

  localparam int SW   = 2 * CW + 2;
  localparam int LW   = CW + 1;
  localparam int NW   = CW + FRAC_BITS;
  localparam int AW   = CW + 36;
  localparam int CNTW = $clog2(NW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SQRT = 3'd2;
  localparam logic [2:0] ST_DLD  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_TEST = 3'd5;
  localparam logic [2:0] ST_RES  = 3'd6;

  localparam logic signed [32:0] RHI = (33'sd1 <<< (CW - 1)) - 33'sd1;
  localparam logic signed [32:0] RLO = -RHI - 33'sd1;
  localparam logic signed [CW-1:0] CMAX = RHI[CW-1:0];
  localparam logic signed [CW-1:0] CMIN = RLO[CW-1:0];
  localparam logic [2:0] LAST_PLANE = 3'(fpe_pkg::NUM_PLANES - 1);

  logic [2:0]            state;
  logic [2:0]            plane;
  logic [1:0]            coef;
  logic [CNTW-1:0]       cnt;
  logic signed [CW-1:0]  raw  [fpe_pkg::NUM_PLANES][fpe_pkg::COEF_PER_PLANE];
  logic signed [CW-1:0]  norm [fpe_pkg::NUM_PLANES][fpe_pkg::COEF_PER_PLANE];
  fpe_pkg::item_t        cur;
  logic [2*CW-1:0]       sq_prod;
  logic [SW-1:0]         sum;
  logic [SW-1:0]         sq_shift;
  logic [CW+2:0]         rem;
  logic [LW-1:0]         root;
  logic [NW-1:0]         num;
  logic [LW-1:0]         dr;
  logic signed [CW+32:0] prod;
  logic signed [AW-1:0]  acc;
  logic                  all_in;

  logic signed [CW-1:0]  rc;
  logic [CW-1:0]         rmag;
  logic [CW+2:0]         rem_in;
  logic [CW+2:0]         trial;
  logic [LW:0]           rt;
  logic                  dge;
  logic [NW-1:0]         qfin;
  logic signed [CW-1:0]  qsat;
  logic signed [CW-1:0]  nc;
  logic signed [32:0]    pos;
  logic signed [32:0]    corner;
  logic signed [AW-1:0]  fin;
  logic                  is_box;

  function automatic logic signed [CW-1:0] sat_row(input logic signed [32:0] v);
    logic signed [CW-1:0] r;
    if (v > RHI) begin
      r = CMAX;
    end else if (v < RLO) begin
      r = CMIN;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

  assign rc     = raw[plane][coef];
  assign rmag   = rc[CW-1] ? (~rc + 1'b1) : rc;
  assign rem_in = {rem[CW:0], sq_shift[SW-1 -: 2]};
  assign trial  = {root, 2'b01};
  assign rt     = {dr, num[NW-1]};
  assign dge    = (rt >= {1'b0, root});
  assign qfin   = {num[NW-2:0], dge};

  always_comb begin
    if (!rc[CW-1]) begin
      qsat = (|qfin[NW-1:CW-1]) ? CMAX : qfin[CW-1:0];
    end else if ((|qfin[NW-1:CW]) || (qfin[CW-1] && (|qfin[CW-2:0]))) begin
      qsat = CMIN;
    end else begin
      qsat = -qfin[CW-1:0];
    end
  end

  assign is_box = (cur.cmd == fpe_pkg::CMD_BOX);
  assign nc     = norm[plane][coef];

  always_comb begin
    case (coef)
      2'd0:    pos = {cur.px[31], cur.px};
      2'd1:    pos = {cur.py[31], cur.py};
      default: pos = {cur.pz[31], cur.pz};
    endcase
    if (!is_box) begin
      corner = pos;
    end else if (!nc[CW-1]) begin
      corner = pos + $signed({2'b00, cur.rad});
    end else begin
      corner = pos - $signed({2'b00, cur.rad});
    end
    fin = acc + AW'(prod) + (AW'(nc) <<< FRAC_BITS);
  end

  assign q_ready    = (state == ST_IDLE);
  assign res_valid  = (state == ST_RES);
  assign res.in_view = all_in;
  assign res.kind    = is_box;

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          cur <= q_item;
          sum <= '0;
        end
      end
      ST_SQ: begin
        sq_prod <= rmag * rmag;
        if (coef != 2'd0) begin
          sum <= sum + SW'(sq_prod);
        end
        sq_shift <= sum + SW'(sq_prod);
        rem  <= '0;
        root <= '0;
      end
      ST_SQRT: begin
        sq_shift <= sq_shift << 2;
        if (rem_in >= trial) begin
          rem  <= rem_in - trial;
          root <= {root[LW-2:0], 1'b1};
        end else begin
          rem  <= rem_in;
          root <= {root[LW-2:0], 1'b0};
        end
      end
      ST_DLD: begin
        num <= {rmag, FRAC_BITS'(0)};
        dr  <= '0;
      end
      ST_DIV: begin
        dr  <= dge ? LW'(rt - {1'b0, root}) : rt[LW-1:0];
        num <= qfin;
        if (coef == 2'd3 && cnt == CNTW'(NW - 1)) begin
          sum <= '0;
        end
      end
      ST_TEST: begin
        prod <= nc * corner;
        if (coef == 2'd0) begin
          acc <= '0;
        end else begin
          acc <= acc + AW'(prod);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      plane  <= '0;
      coef   <= '0;
      cnt    <= '0;
      all_in <= 1'b1;
      for (int p = 0; p < fpe_pkg::NUM_PLANES; p++) begin
        for (int k = 0; k < fpe_pkg::COEF_PER_PLANE; k++) begin
          raw[p][k]  <= '0;
          norm[p][k] <= '0;
        end
      end
    end else begin
      case (state)
        ST_IDLE: begin
          plane  <= '0;
          coef   <= '0;
          all_in <= 1'b1;
          if (q_valid) begin
            if (q_item.cmd == fpe_pkg::CMD_LOAD) begin
              raw[0][q_item.row] <= sat_row(q_item.e3 + q_item.e0);
              raw[1][q_item.row] <= sat_row(q_item.e3 - q_item.e0);
              raw[2][q_item.row] <= sat_row(q_item.e3 + q_item.e1);
              raw[3][q_item.row] <= sat_row(q_item.e3 - q_item.e1);
              raw[4][q_item.row] <= sat_row(q_item.e3 + q_item.e2);
              raw[5][q_item.row] <= sat_row(q_item.e3 - q_item.e2);
              if (q_item.row == 2'd3) begin
                state <= ST_SQ;
              end
            end else begin
              state <= ST_TEST;
            end
          end
        end
        ST_SQ: begin
          coef <= coef + 2'd1;
          cnt  <= '0;
          if (coef == 2'd3) begin
            state <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(LW - 1)) begin
            state <= ST_DLD;
          end
        end
        ST_DLD: begin
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNTW'(NW - 1)) begin
            norm[plane][coef] <= (root == '0) ? '0 : qsat;
            coef <= coef + 2'd1;
            if (coef != 2'd3) begin
              state <= ST_DLD;
            end else if (plane == LAST_PLANE) begin
              state <= ST_IDLE;
            end else begin
              plane <= plane + 3'd1;
              state <= ST_SQ;
            end
          end
        end
        ST_TEST: begin
          coef <= coef + 2'd1;
          if (coef == 2'd3) begin
            if (is_box ? (fin <= 0) : (fin < 0)) begin
              all_in <= 1'b0;
            end
            if (plane == LAST_PLANE) begin
              state <= ST_RES;
            end else begin
              plane <= plane + 3'd1;
            end
          end
        end
        ST_RES: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `FPE_ASSERT_NEXT(a_res_done, res_valid && res_ready, state == ST_IDLE, "result not retired")
  `FPE_ASSERT_NOW(a_plane_range, state != ST_IDLE, plane <= LAST_PLANE, "plane index out of range")
  `FPE_ASSERT_NEXT(a_row3_norm, q_valid && q_ready && q_item.cmd == fpe_pkg::CMD_LOAD && q_item.row == 2'd3, state == ST_SQ, "row three did not start normalisation")
  `FPE_ASSERT_NEXT(a_test_start, q_valid && q_ready && q_item.cmd != fpe_pkg::CMD_LOAD, state == ST_TEST && all_in, "test did not start cleanly")

endmodule
`default_nettype wire

[sv/frustum_plane_extract_and_cull_top.sv]
// ---------------------------------------------------------------------------
// frustum_plane_extract_and_cull_top
// Builds six normalised frustum planes from matrix rows and culls points
// and boxes against them.
// ---------------------------------------------------------------------------
// The slave channel takes one item per handshake: tuser carries the command,
// tdata the row index, four matrix elements, a centre and a box radius.
// Matrix rows return nothing; point and box tests each return one item on
// the master channel with the verdict in tdata and the test kind in tuser.
// A row load only writes the plane store. Row three also starts
// normalisation: per plane a sum of squares, a shared square root and
// four shift-subtract divisions, one per coefficient, for all six planes.
// A test walks the four coefficients of each of the six planes through a
// single multiplier.
// A two-entry queue sits in front of the sequencer and an output register
// behind it, so the receiver can stall while items keep queueing. After
// reset all planes are zero: points test inside and boxes outside.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module frustum_plane_extract_and_cull_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // row_index, elem_0, elem_1, elem_2, elem_3, pos_x, pos_y, pos_z, radius
  input  wire logic [263:0] s_tdata,
  // command
  input  wire logic [1:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // inside_res
  output logic [7:0]        m_tdata,
  // test_kind
  output logic              m_tuser
);

  localparam int CW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

  logic           q_valid;
  logic           q_ready;
  fpe_pkg::item_t q_item;
  logic           res_valid;
  logic           res_ready;
  fpe_pkg::res_t  res;

  fpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  fpe_back #(
    .CW        (CW),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {7'd0, res.in_view};
      m_tuser <= res.kind;
    end
  end

endmodule
`default_nettype wire

[test/frustum_plane_extract_and_cull_top_test.sv]
// ---------------------------------------------------------------------------
// frustum_plane_extract_and_cull_top_test
// Loads view-projection matrices row by row and runs point and box tests
// against the extracted planes. Every verdict is checked against a predictor
// kept in the testbench. The run covers extreme values, zero-length planes
// and partial reloads. It has random phases with idle senders and stalling
// receivers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module frustum_plane_extract_and_cull_top_test;

  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int FB = 16;
  localparam logic signed [31:0] MAXV = 32'sh7fffffff;
  localparam logic signed [31:0] MINV = 32'sh80000000;
  localparam logic signed [31:0] ONE = 32'sh00010000;

  typedef struct {
    logic [1:0]         cmd;
    logic [1:0]         row;
    logic signed [31:0] e[4];
    logic signed [31:0] px, py, pz;
    logic [30:0]        rad;
  } cull_item_t;

  typedef struct {
    bit in_view;
    bit kind;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [263:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tuser;

  cull_item_t pending[$];
  cull_item_t cur = '{cmd: CMD_NONE, row: 2'd0, e: '{0, 0, 0, 0}, px: 0, py: 0, pz: 0, rad: 0};
  verdict_t expected_verdicts[$];
  logic s_took = 1'b0;
  int send_idle = 0;
  int recv_stall = 0;
  int errors = 0;

  longint raw_coef[24];
  longint norm_coef[24];

  frustum_plane_extract_and_cull_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  assign s_tuser = cur.cmd;
  assign s_tdata = {7'd0, cur.rad, cur.pz, cur.py, cur.px,
                    cur.e[3], cur.e[2], cur.e[1], cur.e[0], cur.row};

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  function automatic void normalise_planes();
    longint unsigned s, len, m, q;
    for (int p = 0; p < 6; p++) begin
      s = 0;
      for (int k = 0; k < 3; k++) begin
        m = magnitude(raw_coef[4*p+k]);
        s = s + m * m;
      end
      len = isqrt(s);
      for (int k = 0; k < 4; k++) begin
        if (len == 0) begin
          norm_coef[4*p+k] = 0;
        end else begin
          q = (magnitude(raw_coef[4*p+k]) << FB) / len;
          norm_coef[4*p+k] = sat32(raw_coef[4*p+k] < 0 ? -longint'(q) : longint'(q));
        end
      end
    end
  endfunction

  function automatic longint plane_distance(int p, longint x, longint y, longint z);
    return norm_coef[4*p] * x + norm_coef[4*p+1] * y + norm_coef[4*p+2] * z
           + norm_coef[4*p+3] * (64'sd1 << FB);
  endfunction

  function automatic void predict_culling(cull_item_t it);
    longint x, y, z, r, o;
    bit ok, front;
    verdict_t v;
    x = it.px;
    y = it.py;
    z = it.pz;
    r = longint'({1'b0, it.rad});
    ok = 1;
    case (it.cmd)
      fpe_pkg::CMD_LOAD: begin
        for (int p = 0; p < 6; p++) begin
          o = it.e[p >> 1];
          raw_coef[4*p + it.row] = sat32((p & 1) ? longint'(it.e[3]) - o : longint'(it.e[3]) + o);
        end
        if (it.row == 2'd3) normalise_planes();
      end
      fpe_pkg::CMD_POINT: begin
        for (int p = 0; p < 6; p++)
          if (plane_distance(p, x, y, z) < 0) ok = 0;
        v.in_view = ok;
        v.kind = 0;
        expected_verdicts.push_back(v);
      end
      fpe_pkg::CMD_BOX: begin
        for (int p = 0; p < 6; p++) begin
          front = 0;
          for (int n = 0; n < 8; n++)
            if (plane_distance(p, (n & 1) ? x + r : x - r, (n & 2) ? y + r : y - r,
                               (n & 4) ? z + r : z - r) > 0) front = 1;
          if (!front) ok = 0;
        end
        v.in_view = ok;
        v.kind = 1;
        expected_verdicts.push_back(v);
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_took) begin
      if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
        cur <= pending.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_stall);
  end

  always @(posedge clk) begin
    s_took <= s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) predict_culling(cur);
    if (!rst && m_tvalid && m_tready) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected verdict inside=%0b kind=%0b", m_tdata[0], m_tuser));
      end else begin
        if (m_tdata[0] !== expected_verdicts[0].in_view)
          report_mismatch($sformatf("inside %0b, expected %0b", m_tdata[0],
                                    expected_verdicts[0].in_view));
        if (m_tuser !== expected_verdicts[0].kind)
          report_mismatch($sformatf("kind %0b, expected %0b", m_tuser,
                                    expected_verdicts[0].kind));
        void'(expected_verdicts.pop_front());
      end
    end
  end

  task automatic add_item(logic [1:0] cmd, logic [1:0] row, logic signed [31:0] e0,
                          logic signed [31:0] e1, logic signed [31:0] e2,
                          logic signed [31:0] e3, logic signed [31:0] x,
                          logic signed [31:0] y, logic signed [31:0] z, logic [30:0] r);
    cull_item_t it;
    it.cmd = cmd;
    it.row = row;
    it.e[0] = e0;
    it.e[1] = e1;
    it.e[2] = e2;
    it.e[3] = e3;
    it.px = x;
    it.py = y;
    it.pz = z;
    it.rad = r;
    pending.push_back(it);
  endtask

  function automatic logic signed [31:0] near_value(int span);
    return $signed($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic add_noise();
    add_item(2'($urandom_range(0, 3)), 2'($urandom), $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, 31'($urandom));
  endtask

  task automatic add_test(int span);
    add_item($urandom_range(0, 1) ? fpe_pkg::CMD_BOX : fpe_pkg::CMD_POINT, 2'($urandom),
             $urandom, $urandom, $urandom, $urandom, near_value(span), near_value(span),
             near_value(span), 31'($urandom_range(0, span / 2)));
  endtask

  task automatic drain();
    while (pending.size() > 0 || s_tvalid || expected_verdicts.size() > 0) @(posedge clk);
  endtask

  task automatic run_phase(int idle, int stall, int count);
    int n = 0;
    int span;
    send_idle = idle;
    recv_stall = stall;
    while (n < count) begin
      if ($urandom_range(0, 99) < 85) begin
        span = $urandom_range(0, 1) ? (1 << 18) : (1 << 24);
        for (int r = 0; r < 4; r++)
          add_item(fpe_pkg::CMD_LOAD, 2'(r), near_value(span), near_value(span),
                   near_value(span), near_value(span), $urandom, $urandom, $urandom,
                   31'($urandom));
        for (int t = $urandom_range(10, 30); t > 0; t--) add_test(span);
        n += 24;
      end else begin
        for (int t = 0; t < 8; t++) add_noise();
        n += 8;
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    add_item(fpe_pkg::CMD_POINT, 0, 0, 0, 0, 0, MAXV, MINV, 0, 0);
    add_item(fpe_pkg::CMD_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_BOX, 0, 0, 0, 0, 0, MINV, MAXV, -1, 31'h7fffffff);
    add_item(CMD_NONE, 3, -1, -1, -1, -1, -1, -1, -1, 31'h7fffffff);
    add_item(fpe_pkg::CMD_LOAD, 0, MAXV, MINV, 0, MAXV, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_LOAD, 1, MINV, MAXV, -1, MINV, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_LOAD, 2, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_LOAD, 3, 1, 2, 3, MAXV, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_POINT, 0, 0, 0, 0, 0, MAXV, MAXV, MAXV, 0);
    add_item(fpe_pkg::CMD_POINT, 0, 0, 0, 0, 0, MINV, MINV, MINV, 0);
    add_item(fpe_pkg::CMD_BOX, 0, 0, 0, 0, 0, MINV, MAXV, 0, 31'h7fffffff);
    add_item(fpe_pkg::CMD_LOAD, 0, ONE, 0, 0, 0, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_LOAD, 1, 0, ONE, 0, 0, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_LOAD, 2, 0, 0, ONE, 0, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_LOAD, 3, 0, 0, 0, ONE, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0, ONE, -ONE, 0);
    add_item(fpe_pkg::CMD_POINT, 0, 0, 0, 0, 0, 2 * ONE, 0, 0, 0);
    add_item(fpe_pkg::CMD_BOX, 0, 0, 0, 0, 0, 3 * ONE, 0, 0, 31'(ONE));
    add_item(fpe_pkg::CMD_BOX, 0, 0, 0, 0, 0, 2 * ONE, 0, 0, 31'(ONE));
    add_item(fpe_pkg::CMD_LOAD, 1, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_LOAD, 3, 0, 0, 0, 5 * ONE, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_POINT, 0, 0, 0, 0, 0, 0, MAXV, 0, 0);
    add_item(fpe_pkg::CMD_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_LOAD, 2, 0, 0, 0, 0, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_LOAD, 3, 0, 0, 0, ONE, 0, 0, 0, 0);
    add_item(fpe_pkg::CMD_POINT, 0, 0, 0, 0, 0, 7, 7, 7, 0);
    add_item(fpe_pkg::CMD_BOX, 0, 0, 0, 0, 0, 7, 7, 7, 31'd9);
    drain();
    run_phase(0, 0, 500);
    run_phase(86, 0, 500);
    run_phase(0, 86, 500);
    run_phase(36, 36, 500);
    repeat (1000) @(posedge clk);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("frustum_plane_extract_and_cull_top_test passed");
    end else begin
      $display("frustum_plane_extract_and_cull_top_test failed");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("frustum_plane_extract_and_cull_top_test failed");
    $finish;
  end

endmodule
